// ----- design/drive_start_sequencer_macros.svh -----
// Assertion helpers used by the checker of the drive start sequencer
`ifndef DRIVE_START_SEQUENCER_MACROS_SVH
`define DRIVE_START_SEQUENCER_MACROS_SVH

// same-cycle property, reset masks the check
`define DSS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in this cycle, consequent in the cycle after
`define DSS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/dss_pkg.sv -----
package dss_pkg;

  localparam int unsigned CfgW     = 16;
  localparam int unsigned SinceW   = 17;
  localparam int unsigned ElapsedW = 10;
  localparam int unsigned SpeedW   = 3;
  localparam int unsigned MsgW     = 3;
  localparam int unsigned LostW    = 2;
  localparam int unsigned PhaseW   = 2;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [SinceW-1:0] SinceMax = {SinceW{1'b1}};

  localparam logic [CfgW-1:0] PowerDelayRst = 16'd1000;
  localparam logic [CfgW-1:0] RunDelayRst   = 16'd1000;
  localparam logic [CfgW-1:0] SettleRst     = 16'd500;
  localparam logic [CfgW-1:0] TimeoutRst    = 16'd30000;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_START    = 2'd1,
    OP_STOP     = 2'd2,
    OP_SHUTDOWN = 2'd3
  } dss_op_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POWER_DELAY = 2'd0,
    REG_RUN_DELAY   = 2'd1,
    REG_SETTLE      = 2'd2,
    REG_TIMEOUT     = 2'd3
  } dss_reg_t;

  typedef enum logic [MsgW-1:0] {
    MSG_NONE      = 3'd0,
    MSG_INTERLOCK = 3'd1,
    MSG_NO_SPEED  = 3'd2,
    MSG_RUNNING   = 3'd3,
    MSG_STOPPED   = 3'd4,
    MSG_LOST      = 3'd5,
    MSG_TIMEOUT   = 3'd6,
    MSG_CLEARED   = 3'd7
  } dss_msg_t;

  typedef enum logic [LostW-1:0] {
    LOST_NONE    = 2'd0,
    LOST_CONTROL = 2'd1,
    LOST_READY   = 2'd2,
    LOST_RUNNING = 2'd3
  } dss_lost_t;

  // phase code as reported on the result
  localparam logic [PhaseW-1:0] PH_CODE_IDLE    = 2'd0;
  localparam logic [PhaseW-1:0] PH_CODE_POWER   = 2'd1;
  localparam logic [PhaseW-1:0] PH_CODE_RUN     = 2'd2;
  localparam logic [PhaseW-1:0] PH_CODE_MONITOR = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_POWER   = 4'b0010,
    PH_RUN     = 4'b0100,
    PH_MONITOR = 4'b1000
  } dss_phase_t;

  typedef struct packed {
    logic [CfgW-1:0] power_delay_ms;
    logic [CfgW-1:0] run_delay_ms;
    logic [CfgW-1:0] settle_ms;
    logic [CfgW-1:0] run_timeout_ms;
  } dss_cfg_t;

  typedef struct packed {
    dss_op_t             opcode;
    logic [ElapsedW-1:0] elapsed_ms;
    logic                control_ok;
    logic                converter_ready;
    logic                converter_running;
    logic [SpeedW-1:0]   speed_select;
  } dss_in_t;

  typedef struct packed {
    dss_phase_t        phase;
    logic [SinceW-1:0] since_ms;
    logic              power_level;
    logic              run_level;
    logic [SpeedW-1:0] speed_level;
  } dss_state_t;

  typedef struct packed {
    logic              power_on;
    logic              run_forward;
    logic [SpeedW-1:0] speed_code;
    dss_msg_t          message;
    dss_lost_t         lost_signal;
    logic [PhaseW-1:0] phase_now;
  } dss_out_t;

endpackage

// ----- design/dss_cfg_regs.sv -----
module dss_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [dss_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dss_pkg::CfgW-1:0]      cfg_wdata,
  output dss_pkg::dss_cfg_t             cfg
);
  import dss_pkg::*;

  dss_cfg_t cfg_r;
  dss_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (dss_reg_t'(cfg_index))
        REG_POWER_DELAY: cfg_nxt.power_delay_ms = cfg_wdata;
        REG_RUN_DELAY:   cfg_nxt.run_delay_ms   = cfg_wdata;
        REG_SETTLE:      cfg_nxt.settle_ms      = cfg_wdata;
        REG_TIMEOUT:     cfg_nxt.run_timeout_ms = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_delay_ms <= PowerDelayRst;
      cfg_r.run_delay_ms   <= RunDelayRst;
      cfg_r.settle_ms      <= SettleRst;
      cfg_r.run_timeout_ms <= TimeoutRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/dss_step.sv -----
module dss_step (
  input  dss_pkg::dss_in_t    item,
  input  dss_pkg::dss_state_t st,
  input  dss_pkg::dss_cfg_t   cfg,
  output dss_pkg::dss_state_t st_nxt,
  output dss_pkg::dss_out_t   res
);
  import dss_pkg::*;

  logic [SinceW:0]   since_sum;
  logic [SinceW-1:0] since_sat;
  logic [SinceW-1:0] run_limit;
  logic              all_ok;
  dss_msg_t          msg;
  dss_lost_t         lost;
  logic [PhaseW-1:0] phase_code;

  assign since_sum = {1'b0, st.since_ms} + {{(SinceW + 1 - ElapsedW){1'b0}}, item.elapsed_ms};
  assign since_sat = since_sum[SinceW] ? SinceMax : since_sum[SinceW-1:0];
  // settle plus timeout, both counted from run on
  assign run_limit = {1'b0, cfg.settle_ms} + {1'b0, cfg.run_timeout_ms};
  assign all_ok    = item.control_ok && item.converter_ready && item.converter_running;

  always_comb begin
    st_nxt          = st;
    st_nxt.since_ms = since_sat;
    msg             = MSG_NONE;
    lost            = LOST_NONE;

    priority if (item.opcode == OP_START) begin
      priority if (!all_ok) begin
        msg          = MSG_INTERLOCK;
        st_nxt.phase = PH_IDLE;
      end else if (item.speed_select == '0) begin
        msg          = MSG_NO_SPEED;
        st_nxt.phase = PH_IDLE;
      end else begin
        st_nxt.speed_level = st.speed_level | item.speed_select;
        st_nxt.since_ms    = '0;
        st_nxt.phase       = PH_POWER;
        msg                = MSG_CLEARED;
      end
    end else if (item.opcode == OP_STOP || item.opcode == OP_SHUTDOWN) begin
      st_nxt.run_level   = 1'b0;
      st_nxt.speed_level = '0;
      st_nxt.phase       = PH_IDLE;
      msg                = (item.opcode == OP_STOP) ? MSG_STOPPED : MSG_NONE;
    end else begin
      unique case (st.phase)
        PH_IDLE: ;
        PH_POWER: begin
          if (since_sat > {1'b0, cfg.power_delay_ms}) begin
            st_nxt.power_level = 1'b1;
            st_nxt.since_ms    = '0;
            st_nxt.phase       = PH_RUN;
          end
        end
        PH_RUN: begin
          if (since_sat > {1'b0, cfg.run_delay_ms}) begin
            st_nxt.run_level = 1'b1;
            st_nxt.since_ms  = '0;
            st_nxt.phase     = PH_MONITOR;
            msg              = MSG_RUNNING;
          end
        end
        PH_MONITOR: begin
          if (since_sat > {1'b0, cfg.settle_ms}) begin
            priority if (!item.control_ok)      lost = LOST_CONTROL;
            else if (!item.converter_ready)     lost = LOST_READY;
            else if (!item.converter_running)   lost = LOST_RUNNING;
            else                                lost = LOST_NONE;
          end
          // a lost interlock wins over the timeout
          priority if (lost != LOST_NONE) begin
            st_nxt.power_level = 1'b0;
            st_nxt.run_level   = 1'b0;
            st_nxt.speed_level = '0;
            st_nxt.phase       = PH_IDLE;
            msg                = MSG_LOST;
          end else if (since_sat > run_limit) begin
            st_nxt.run_level   = 1'b0;
            st_nxt.speed_level = '0;
            st_nxt.phase       = PH_IDLE;
            msg                = MSG_TIMEOUT;
          end else begin
            msg = MSG_NONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (st_nxt.phase)
      PH_IDLE:    phase_code = PH_CODE_IDLE;
      PH_POWER:   phase_code = PH_CODE_POWER;
      PH_RUN:     phase_code = PH_CODE_RUN;
      PH_MONITOR: phase_code = PH_CODE_MONITOR;
      default:    phase_code = PH_CODE_IDLE;
    endcase
  end

  assign res.power_on    = st_nxt.power_level;
  assign res.run_forward = st_nxt.run_level;
  assign res.speed_code  = st_nxt.speed_level;
  assign res.message     = msg;
  assign res.lost_signal = lost;
  assign res.phase_now   = phase_code;

endmodule

// ----- design/drive_start_sequencer.sv -----
// An accepted transaction enters the input register, then its result enters the
// result register that drives out_tvalid. Throughput: one transaction per cycle
// while out_tready holds high; the input register and the result register each
// take a new item whenever the result register is free or drained.
// Reset (rst_n low, synchronous): idle phase, elapsed counter and output levels
// cleared, delay registers back to 1000/1000/500/30000 ms, both stages empty.
module drive_start_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [9:0] elapsed_ms, [10] control_ok, [11] converter_ready,
  // [12] converter_running, [15:13] speed_select
  input  logic [dss_pkg::InDataW-1:0]    in_tdata,
  // [1:0] opcode
  input  logic [dss_pkg::InUserW-1:0]    in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] power_on, [1] run_forward, [4:2] speed_code, [7:5] message,
  // [9:8] lost_signal, [11:10] phase_now, [15:12] zero
  output logic [dss_pkg::OutDataW-1:0]   out_tdata,
  input  logic                           cfg_wr_en,
  input  logic [dss_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [dss_pkg::CfgW-1:0]       cfg_wdata
);
  import dss_pkg::*;

  dss_cfg_t   cfg;
  dss_in_t    in_item;
  dss_in_t    item_r;
  logic       item_valid_r;
  dss_state_t st_r;
  dss_state_t st_nxt;
  dss_out_t   res;
  dss_out_t   res_r;
  logic       out_valid_r;
  logic       advance;

  dss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_item.opcode            = dss_op_t'(in_tuser);
  assign in_item.elapsed_ms        = in_tdata[9:0];
  assign in_item.control_ok        = in_tdata[10];
  assign in_item.converter_ready   = in_tdata[11];
  assign in_item.converter_running = in_tdata[12];
  assign in_item.speed_select      = in_tdata[15:13];

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

  dss_step u_step (
    .item   (item_r),
    .st     (st_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // state moves exactly once per item, when it enters the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= PH_IDLE;
      st_r.since_ms    <= '0;
      st_r.power_level <= 1'b0;
      st_r.run_level   <= 1'b0;
      st_r.speed_level <= '0;
      out_valid_r      <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
      if (item_valid_r) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid_r) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r.phase_now, res_r.lost_signal, res_r.message,
                       res_r.speed_code, res_r.run_forward, res_r.power_on};

endmodule

// ----- design/dss_checker.sv -----
`include "drive_start_sequencer_macros.svh"

module dss_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [dss_pkg::OutDataW-1:0] out_tdata
);
  import dss_pkg::*;

  logic              power_on;
  logic              run_forward;
  logic [MsgW-1:0]   message;
  logic [LostW-1:0]  lost_signal;
  logic [PhaseW-1:0] phase_now;

  assign power_on    = out_tdata[0];
  assign run_forward = out_tdata[1];
  assign message     = out_tdata[7:5];
  assign lost_signal = out_tdata[9:8];
  assign phase_now   = out_tdata[11:10];

  `DSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `DSS_ASSERT(a_run_needs_power, clk, rst_n, !out_tvalid || !run_forward || power_on, "run without power")
  `DSS_ASSERT(a_monitor_runs, clk, rst_n, !out_tvalid || phase_now != PH_CODE_MONITOR || run_forward, "monitoring without run")
  `DSS_ASSERT(a_lost_msg, clk, rst_n, !out_tvalid || lost_signal == LOST_NONE || message == MSG_LOST, "lost interlock without its message")

endmodule

bind drive_start_sequencer dss_checker u_dss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
